FILE: sv/fvn_pkg.sv
package fvn_pkg;

	localparam int VAL_W     = 24;
	localparam int WGT_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE = 2'd1;

	localparam logic [31:0] HASH_X_MUL = 32'h9e37_79b1;
	localparam logic [31:0] HASH_Y_MUL = 32'h85eb_ca6b;
	localparam logic [31:0] MIX_MUL_A  = 32'h7feb_352d;
	localparam logic [31:0] MIX_MUL_B  = 32'h846c_a68b;
	localparam logic [31:0] SEED_STEP  = 32'd1013;
	localparam logic [17:0] EASE_THREE = 18'd196608;

	typedef struct packed {
		logic [31:0] y;
		logic [31:0] x;
	} point_t;

	// first step of the avalanche: shift-xor then multiply
	function automatic logic [31:0] mix_a(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 16);
		return t * MIX_MUL_A;
	endfunction

	function automatic logic [31:0] mix_b(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 15);
		return t * MIX_MUL_B;
	endfunction

	function automatic logic [31:0] mix_c(input logic [31:0] v);
		return v ^ (v >> 16);
	endfunction

	// smoothstep second product, t*t already formed
	function automatic logic [WGT_W-1:0] ease(input logic [31:0] tt, input logic [WGT_W-1:0] t);
		logic [49:0] p;
		p = 50'(tt) * 50'(EASE_THREE - {1'b0, t, 1'b0});
		return p[47:32];
	endfunction

	// a + floor((b - a) * w / 2^16)
	function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b, input logic [WGT_W-1:0] w);
		logic signed [VAL_W:0]   d;
		logic signed [WGT_W:0]   ws;
		logic signed [41:0]      prod;
		logic signed [41:0]      res;
		d    = $signed({1'b0, b}) - $signed({1'b0, a});
		ws   = $signed({1'b0, w});
		prod = 42'(d) * 42'(ws);
		res  = $signed(42'({1'b0, a})) + (prod >>> 16);
		return res[VAL_W-1:0];
	endfunction

endpackage

FILE: sv/fvn_octave_cell.sv
module fvn_octave_cell #(
	parameter int OCT = 0,
	parameter int FB  = 16,
	parameter int AW  = 32,
	parameter int CW  = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [CW-1:0]   cnt,
	input  logic [31:0]     seed,
	input  logic            in_valid,
	input  fvn_pkg::point_t in_pt,
	input  logic [AW-1:0]   in_acc,
	output logic            out_valid,
	output fvn_pkg::point_t out_pt,
	output logic [AW-1:0]   out_acc
);
	import fvn_pkg::*;

	localparam int L = 10;

	logic [63:0]       px, py;
	logic [WGT_W-1:0]  tx, ty;
	logic [31:0]       oseed;
	logic              on;

	logic [L-1:0]      vld_q;
	point_t            pt_q [L];
	logic [AW-1:0]     acc_q [L-1];

	logic [31:0]       x0_s1, x1_s1, y0_s1, y1_s1;
	logic [WGT_W-1:0]  tx_s1, ty_s1, tx_s2, ty_s2;
	logic [31:0]       ttx_s2, tty_s2;
	logic [31:0]       h_s2 [4];
	logic [31:0]       h_s3 [4];
	logic [31:0]       h_s4 [4];
	logic [31:0]       c_s5 [4];
	logic [31:0]       c_s6 [4];
	logic [VAL_W-1:0]  v_s7 [4];
	logic [WGT_W-1:0]  wx_q [5];
	logic [WGT_W-1:0]  wy_q [6];
	logic [VAL_W-1:0]  r0_s8, r1_s8, n_s9;
	logic [AW-1:0]     acc_s10;

	assign px    = 64'($signed(in_pt.x)) << OCT;
	assign py    = 64'($signed(in_pt.y)) << OCT;
	assign oseed = seed + 32'(SEED_STEP * 32'(OCT));
	assign on    = cnt > CW'(OCT);

	generate
		if (FB >= WGT_W) begin : g_trunc
			assign tx = px[FB-1 -: WGT_W];
			assign ty = py[FB-1 -: WGT_W];
		end else begin : g_pad
			assign tx = {px[FB-1:0], {(WGT_W-FB){1'b0}}};
			assign ty = {py[FB-1:0], {(WGT_W-FB){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_q[0]  <= in_pt;
			acc_q[0] <= in_acc;
			for (int k = 1; k < L; k++) pt_q[k] <= pt_q[k-1];
			for (int k = 1; k < L - 1; k++) acc_q[k] <= acc_q[k-1];

			// lattice corners and fractions
			x0_s1 <= px[FB+31:FB];
			x1_s1 <= px[FB+31:FB] + 32'd1;
			y0_s1 <= py[FB+31:FB];
			y1_s1 <= py[FB+31:FB] + 32'd1;
			tx_s1 <= tx;
			ty_s1 <= ty;

			h_s2[0] <= x0_s1 * HASH_X_MUL;
			h_s2[1] <= x1_s1 * HASH_X_MUL;
			h_s2[2] <= y0_s1 * HASH_Y_MUL;
			h_s2[3] <= y1_s1 * HASH_Y_MUL;
			ttx_s2  <= 32'(tx_s1) * 32'(tx_s1);
			tty_s2  <= 32'(ty_s1) * 32'(ty_s1);
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;

			for (int k = 0; k < 4; k++) h_s3[k] <= mix_a(h_s2[k]);
			wx_q[0] <= ease(ttx_s2, tx_s2);
			wy_q[0] <= ease(tty_s2, ty_s2);

			for (int k = 0; k < 4; k++) h_s4[k] <= mix_b(h_s3[k]);
			for (int k = 1; k < 5; k++) wx_q[k] <= wx_q[k-1];
			for (int k = 1; k < 6; k++) wy_q[k] <= wy_q[k-1];

			// corner order 00, 10, 01, 11
			c_s5[0] <= mix_a(oseed ^ mix_c(h_s4[0]) ^ mix_c(h_s4[2]));
			c_s5[1] <= mix_a(oseed ^ mix_c(h_s4[1]) ^ mix_c(h_s4[2]));
			c_s5[2] <= mix_a(oseed ^ mix_c(h_s4[0]) ^ mix_c(h_s4[3]));
			c_s5[3] <= mix_a(oseed ^ mix_c(h_s4[1]) ^ mix_c(h_s4[3]));

			for (int k = 0; k < 4; k++) c_s6[k] <= mix_b(c_s5[k]);
			for (int k = 0; k < 4; k++) v_s7[k] <= VAL_W'(mix_c(c_s6[k]));

			r0_s8 <= blend(v_s7[0], v_s7[1], wx_q[4]);
			r1_s8 <= blend(v_s7[2], v_s7[3], wx_q[4]);
			n_s9  <= blend(r0_s8, r1_s8, wy_q[5]);

			acc_s10 <= on ? ({acc_q[L-2][AW-2:0], 1'b0} + AW'(n_s9)) : acc_q[L-2];
		end
	end

	assign out_valid = vld_q[L-1];
	assign out_pt    = pt_q[L-1];
	assign out_acc   = acc_s10;

endmodule

FILE: sv/fractal_value_noise_2d_top.sv
// path: an input item passes through every octave cell in turn, then the divider
// stages and finally the output register
// throughput: one item per cycle; every octave cell and divider step is fully pipelined
// a skid entry takes one result behind a held output item; with both full the pipe holds
// reset: arst_n clears all valid bits, noise_seed to 0 and octave_count to 2
module fractal_value_noise_2d_top #(
	parameter int MAX_OCTAVES   = 8,
	parameter int FRACTION_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,   // x_coord, y_coord
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // noise_value
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data
);
	import fvn_pkg::*;

	localparam int AW = VAL_W + MAX_OCTAVES;   // weighted sum width
	localparam int CW = $clog2(MAX_OCTAVES + 1);
	localparam int RW = MAX_OCTAVES;           // divisor / remainder width
	localparam int DS = VAL_W;                 // divider steps

	// configuration registers
	logic [31:0]   noise_seed_q;
	logic [3:0]    octave_count_q;
	logic [CW-1:0] cnt;
	logic [RW-1:0] divisor;
	logic          en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q   <= '0;
			octave_count_q <= 4'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SEED:   noise_seed_q   <= cfg_data;
				CFG_OCTAVE: octave_count_q <= cfg_data[3:0];
				default:    ;
			endcase
		end
	end

	// saturate the octave count to the cells we have
	assign cnt = ({1'b0, octave_count_q} > 5'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES)
	                                                         : CW'(octave_count_q);
	// total weight 2^cnt - 1
	assign divisor = RW'((RW+1)'(1) << cnt) - RW'(1);

	// chain of octave cells; each cell below the octave count doubles the running sum and adds one octave
	logic          c_vld [MAX_OCTAVES+1];
	point_t        c_pt  [MAX_OCTAVES+1];
	logic [AW-1:0] c_acc [MAX_OCTAVES+1];

	assign c_vld[0] = s_tvalid;
	assign c_pt[0]  = point_t'(s_tdata);
	assign c_acc[0] = '0;

	generate
		for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
			fvn_octave_cell #(
				.OCT(i), .FB(FRACTION_BITS), .AW(AW), .CW(CW)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (en),
				.cnt      (cnt),
				.seed     (noise_seed_q),
				.in_valid (c_vld[i]),
				.in_pt    (c_pt[i]),
				.in_acc   (c_acc[i]),
				.out_valid(c_vld[i+1]),
				.out_pt   (c_pt[i+1]),
				.out_acc  (c_acc[i+1])
			);
		end
	endgenerate

	// restoring divider, one quotient bit per stage; the sum is below
	// divisor * 2^24 so the top bits already form a valid remainder
	logic [DS:0]      dv_q;
	logic [AW-1:0]    dsum_q [DS+1];
	logic [RW-1:0]    drem_q [DS+1];
	logic [VAL_W-1:0] dquo_q [DS+1];
	logic [DS:0]      dz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
		end else if (en) begin
			dv_q <= {dv_q[DS-1:0], c_vld[MAX_OCTAVES]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dsum_q[0] <= c_acc[MAX_OCTAVES];
			drem_q[0] <= c_acc[MAX_OCTAVES][AW-1:VAL_W];
			dquo_q[0] <= '0;
			dz_q[0]   <= (cnt == '0);
		end
	end

	generate
		for (genvar j = 1; j <= DS; j++) begin : g_div
			logic [RW:0] trial;
			logic        take;
			assign trial = {drem_q[j-1], dsum_q[j-1][DS-j]};
			assign take  = trial >= {1'b0, divisor};
			always_ff @(posedge clk) begin
				if (en) begin
					dsum_q[j] <= dsum_q[j-1];
					drem_q[j] <= take ? RW'(trial - {1'b0, divisor}) : RW'(trial);
					// quotient bit for this stage is still zero on the way in
					dquo_q[j] <= dquo_q[j-1] | (VAL_W'(take) << (DS - j));
					dz_q[j]   <= dz_q[j-1];
				end
			end
		end
	endgenerate

	// output register plus skid entry
	logic             push;
	logic [VAL_W-1:0] push_d;
	logic             main_v_q, skid_v_q;
	logic [VAL_W-1:0] main_d_q, skid_d_q;

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign push     = en && dv_q[DS];
	assign push_d   = dz_q[DS] ? '0 : dquo_q[DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (m_tready || !main_v_q) begin
			main_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !main_v_q) begin
			main_d_q <= skid_v_q ? skid_d_q : push_d;
		end else if (push) begin
			skid_d_q <= push_d;
		end
	end

	assign m_tvalid = main_v_q;
	assign m_tdata  = main_d_q;

`ifndef NO_ASSERTIONS
	// skid entry only fills behind a held result
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q) else $error("skid holds item with empty output");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(main_v_q && !m_tready))
		else $error("skid filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && m_tready |=> m_tvalid && (m_tdata == $past(skid_d_q)))
		else $error("skid item lost on drain");
`endif

endmodule

FILE: tb/fvn_checker.sv
module fvn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          sample_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import fvn_pkg::*;

	localparam int OCT_LIMIT = 8;

	logic [31:0] seed_reg;
	logic [3:0]  octaves_reg;
	logic [23:0] noise_q[$];

	function automatic logic [31:0] avalanche(input logic [31:0] v);
		v = v ^ (v >> 16);
		v = v * 32'h7feb352d;
		v = v ^ (v >> 15);
		v = v * 32'h846ca68b;
		v = v ^ (v >> 16);
		return v;
	endfunction

	function automatic logic [63:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
		input logic [31:0] sd);
		logic [31:0] n;
		n = sd ^ avalanche(cx * 32'h9e3779b1) ^ avalanche(cy * 32'h85ebca6b);
		return {32'd0, avalanche(n) & 32'h00ffffff};
	endfunction

	function automatic logic [63:0] smooth(input logic [63:0] t);
		return (t * t * (64'd196608 - 64'd2 * t)) >> 32;
	endfunction

	function automatic logic [63:0] lerp(input logic [63:0] a, input logic [63:0] b,
		input logic [63:0] w);
		return (a * (64'd65536 - w) + b * w) >> 16;
	endfunction

	function automatic logic [23:0] fractal_noise(input logic [31:0] xc, input logic [31:0] yc,
		input logic [31:0] sd, input logic [3:0] oct);
		logic [63:0] xs, ys, px, py, wx, wy, r0, r1, sum, total;
		logic [31:0] x0, y0, os;
		int cnt;
		xs = {{32{xc[31]}}, xc};
		ys = {{32{yc[31]}}, yc};
		cnt = (oct > OCT_LIMIT) ? OCT_LIMIT : oct;
		if (cnt == 0)
			return 24'd0;
		sum = 0;
		for (int i = 0; i < cnt; i++) begin
			os = sd + 32'd1013 * i;
			px = xs << i;
			py = ys << i;
			x0 = px[47:16];
			y0 = py[47:16];
			wx = smooth({48'd0, px[15:0]});
			wy = smooth({48'd0, py[15:0]});
			r0 = lerp(lattice_hash(x0, y0, os), lattice_hash(x0 + 1, y0, os), wx);
			r1 = lerp(lattice_hash(x0, y0 + 1, os), lattice_hash(x0 + 1, y0 + 1, os), wx);
			sum += lerp(r0, r1, wy) << (cnt - 1 - i);
		end
		total = (64'd1 << cnt) - 1;
		return 24'(sum / total);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg <= '0;
			octaves_reg <= 4'd2;
			fail_count <= 0;
			sample_count <= 0;
			pending <= 0;
			noise_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SEED)
					seed_reg <= cfg_data;
				else if (cfg_index == CFG_OCTAVE)
					octaves_reg <= cfg_data[3:0];
			end
			if (m_tvalid && m_tready) begin
				sample_count <= sample_count + 1;
				if (noise_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					if (noise_q[0] !== m_tdata) begin
						$display("%0t: noise_value mismatch, expected %h actual %h",
							$time, noise_q[0], m_tdata);
						fail_count <= fail_count + 1;
					end
					void'(noise_q.pop_front());
				end
			end
			if (s_tvalid && s_tready)
				noise_q.push_back(fractal_noise(s_tdata[31:0], s_tdata[63:32],
					seed_reg, octaves_reg));
			pending <= noise_q.size();
		end
	end
endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fvn_pkg::*;

	// an index past the last register
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0, s_tready;
	logic [63:0] s_tdata = '0;   // x_coord, y_coord
	logic m_tvalid, m_tready = 1'b0;
	logic [23:0] m_tdata;        // noise_value
	logic cfg_valid = 1'b0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int fail_count, pending, sample_count;
	int send_idle_pct = 0;   // chance per cycle that the sender holds off
	int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
	int drain_limit;

	// pipeline length rounded up, for the pauses in drain and at the end
	localparam int PIPE_CYCLES = 120;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	fractal_value_noise_2d_top dut (.*);

	fvn_checker chk (.*);

	// receiver back-pressure, redrawn each cycle
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// send one item, honoring the idle chance before it
	task automatic send_point(input logic [31:0] xc, input logic [31:0] yc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {yc, xc};
		do @(posedge clk); while (!s_tready);
	endtask

	// wait for all results, then let the pipe settle before a register write
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	// random coordinate: mostly moderate magnitudes, sometimes full range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
			2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return 32'($signed($urandom_range(0, 32'h3fff_ffff)) - 32'sh2000_0000);
		endcase
	endfunction

	initial begin
		#3ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [31:0] edge_vals[8];
		int phase;
		edge_vals = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
			32'h0000_ffff, 32'h0001_0000, 32'h0000_8000, 32'hffff_0000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then zero octaves, max, saturated count, seed wrap
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[i], edge_vals[7 - i]);
		drain();
		write_reg(CFG_OCTAVE, 32'd0);
		send_point(32'h1234_5678, 32'h8765_4321);
		drain();
		write_reg(CFG_OCTAVE, 32'd8);
		write_reg(CFG_SEED, 32'hffff_fffe);
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[i], edge_vals[i]);
		drain();
		write_reg(CFG_OCTAVE, 32'd15);
		write_reg(CFG_SEED, 32'hffff_ffff);
		for (int i = 0; i < 4; i++)
			send_point(edge_vals[2 * i + 1], edge_vals[2 * i]);
		drain();
		// out-of-range index must be ignored
		write_reg(CFG_UNUSED, 32'h0000_0001);
		send_point(32'h0003_8000, 32'hfffc_4000);

		// random phases: new settings each, idling patterns rotate
		for (phase = 0; phase < 12; phase++) begin
			drain();
			write_reg(CFG_SEED, (phase == 0) ? 32'h0 : $urandom());
			write_reg(CFG_OCTAVE, (phase % 4 == 0) ? 32'(phase % 16)
				: 32'($urandom_range(15)));
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			for (int k = 0; k < 102; k++) begin
				if (k == 50) begin
					// sender holds off until every result is back
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_point(rand_coord(), rand_coord());
			end
		end
		s_tvalid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);

		drain_limit = 0;
		while (pending != 0 && drain_limit < 100000) begin
			@(posedge clk);
			drain_limit++;
		end
		repeat (PIPE_CYCLES) @(posedge clk);
		$display("covered %0d results: edge coordinates, octave counts 0 to 15, seed wrap,",
			sample_count);
		$display("ignored register index, and random points under four idling patterns");
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
